// ===== src/lpki_pkg.sv =====
// Shared types and constants for the linear-probe key index.
package lpki_pkg;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_FETCH  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ERROR     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_CMP,
        BK_WRITE,
        BK_DONE
    } bk_state_t;

endpackage

// ===== src/lpki_front.sv =====
// Front end: hashes key bytes, collects the key and posts a command at key_last.
module lpki_front
    import lpki_pkg::*;
#(
    parameter int KEY_BYTES = 32,
    parameter int PAYLOAD_LIMIT = 4096,
    parameter int KW = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic                    has_byte,
    input  logic [7:0]              key_byte,
    input  logic                    key_last,
    input  logic [31:0]             value_handle,
    input  logic [15:0]             payload_length,
    // command toward the back end
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output logic [1:0]              cmd_op,
    output logic                    cmd_bad,
    output logic [31:0]             cmd_hash,
    output logic [KW-1:0]           cmd_len,
    output logic [KEY_BYTES*8-1:0]  cmd_key,
    output logic [31:0]             cmd_handle,
    output logic [15:0]             cmd_plen
);

    logic [31:0]            hash_reg;
    logic [KW-1:0]          count_reg;
    logic                   ovf_reg;
    logic [KEY_BYTES*8-1:0] key_reg;
    logic                   cmd_valid_reg;
    logic [1:0]             op_reg;
    logic                   bad_reg;
    logic [31:0]            chash_reg;
    logic [KW-1:0]          clen_reg;
    logic [KEY_BYTES*8-1:0] ckey_reg;
    logic [31:0]            chandle_reg;
    logic [15:0]            cplen_reg;

    logic                   accept;
    logic [31:0]            hash_next;
    logic                   room;
    logic [KW-1:0]          count_next;
    logic                   ovf_next;
    logic [KEY_BYTES*8-1:0] key_next;

    // one-entry command queue: accept while empty or draining
    assign in_ready = !cmd_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < KW'(KEY_BYTES - 1);

    always_comb
    begin
        hash_next  = hash_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        key_next   = key_reg;
        if (has_byte)
        begin
            hash_next = (hash_reg ^ {24'd0, key_byte}) * HASH_PRIME;
            if (room)
            begin
                key_next[count_reg*8 +: 8] = key_byte;
                count_next = count_reg + KW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_BASIS;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            key_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && key_last)
                cmd_valid_reg <= 1'b1;
            else if (cmd_valid_reg && cmd_ready)
                cmd_valid_reg <= 1'b0;
            if (accept)
            begin
                if (key_last)
                begin
                    hash_reg  <= HASH_BASIS;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    key_reg   <= '0;
                end
                else
                begin
                    hash_reg  <= hash_next;
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                    key_reg   <= key_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && key_last)
        begin
            op_reg      <= operation;
            chash_reg   <= hash_next;
            clen_reg    <= count_next;
            ckey_reg    <= key_next;
            chandle_reg <= value_handle;
            cplen_reg   <= payload_length;
            // overlong key always fails; an overlong payload only matters on store
            bad_reg     <= ovf_next || (operation == OP_STORE &&
                           {16'd0, payload_length} >= 32'(PAYLOAD_LIMIT));
        end
    end

    assign cmd_valid  = cmd_valid_reg;
    assign cmd_op     = op_reg;
    assign cmd_bad    = bad_reg;
    assign cmd_hash   = chash_reg;
    assign cmd_len    = clen_reg;
    assign cmd_key    = ckey_reg;
    assign cmd_handle = chandle_reg;
    assign cmd_plen   = cplen_reg;

endmodule

// ===== src/lpki_back.sv =====
// Back end: bucket memories and the probe walk for store, fetch and remove.
module lpki_back
    import lpki_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int KEY_BYTES = 32,
    parameter int KW = 6,
    parameter int BW = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  logic [1:0]              cmd_op,
    input  logic                    cmd_bad,
    input  logic [31:0]             cmd_hash,
    input  logic [KW-1:0]           cmd_len,
    input  logic [KEY_BYTES*8-1:0]  cmd_key,
    input  logic [31:0]             cmd_handle,
    input  logic [15:0]             cmd_plen,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [31:0]             found_handle,
    output logic [15:0]             found_length
);

    localparam int LW = KW + 1;   // length + live packed in one word
    localparam int CW = BW + 1;   // probe counter holds BUCKETS itself

    logic [LW-1:0]          meta_mem [BUCKETS];
    logic [KEY_BYTES*8-1:0] key_mem  [BUCKETS];
    logic [31:0]            hdl_mem  [BUCKETS];
    logic [15:0]            plen_mem [BUCKETS];

    bk_state_t              state_reg, state_next;
    logic [BW-1:0]          addr_reg, addr_next;
    logic [CW-1:0]          probes_reg, probes_next;
    logic [LW-1:0]          meta_rd_reg;
    logic [KEY_BYTES*8-1:0] key_rd_reg;
    logic [31:0]            hdl_rd_reg;
    logic [15:0]            plen_rd_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [31:0]            fh_reg, fh_next;
    logic [15:0]            fl_reg, fl_next;
    logic                   eq_reg;

    logic                   meta_we;
    logic [LW-1:0]          meta_wd;
    logic                   full_we;
    logic                   slot_empty;
    logic                   slot_live;
    logic                   len_eq;
    logic [BW-1:0]          start_addr;
    logic [KEY_BYTES*8-1:0] key_mask;

    // BUCKETS must be a power of two (unchecked): hash mod BUCKETS is the low bits,
    // and the 32-bit wrap of hash + i lands on the same bucket as wrapping the address
    assign start_addr = cmd_hash[BW-1:0];
    assign slot_live  = meta_rd_reg[0];
    assign slot_empty = (meta_rd_reg[LW-1:1] == '0) && !slot_live;
    assign len_eq     = meta_rd_reg[LW-1:1] == cmd_len;

    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
            key_mask[i*8 +: 8] = (i < int'(cmd_len)) ? 8'hff : 8'h00;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        probes_next    = probes_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        fh_next        = fh_reg;
        fl_next        = fl_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                addr_next = addr_reg + BW'(1);
                if (probes_reg == CW'(BUCKETS - 1))
                    state_next = BK_IDLE;
                probes_next = probes_reg + CW'(1);
            end
            BK_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    addr_next   = start_addr;
                    probes_next = '0;
                    fh_next     = '0;
                    fl_next     = '0;
                    if (cmd_bad || cmd_op == OP_BAD)
                    begin
                        status_next = (cmd_op == OP_STORE || cmd_op == OP_BAD) ?
                                      ST_ERROR : ST_NOT_FOUND;
                        state_next  = BK_DONE;
                    end
                    else
                    begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
                state_next = BK_CHECK;
            BK_CHECK:
                state_next = BK_CMP;
            BK_CMP:
            begin
                if (cmd_op == OP_STORE)
                begin
                    if (slot_empty || (len_eq && eq_reg))
                    begin
                        status_next = ST_OK;
                        state_next  = BK_WRITE;
                    end
                end
                else if (slot_empty)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = BK_DONE;
                end
                else if (len_eq && eq_reg)
                begin
                    if (slot_live)
                    begin
                        status_next = ST_OK;
                        if (cmd_op == OP_FETCH)
                        begin
                            fh_next    = hdl_rd_reg;
                            fl_next    = plen_rd_reg;
                            state_next = BK_DONE;
                        end
                        else
                        begin
                            state_next = BK_WRITE;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = BK_DONE;
                    end
                end
                if (state_next == BK_CMP)
                begin
                    if (probes_reg == CW'(BUCKETS - 1))
                    begin
                        status_next = (cmd_op == OP_STORE) ? ST_ERROR : ST_NOT_FOUND;
                        state_next  = BK_DONE;
                    end
                    else
                    begin
                        probes_next = probes_reg + CW'(1);
                        addr_next   = (addr_reg == BW'(BUCKETS - 1)) ? '0 :
                                      addr_reg + BW'(1);
                        state_next  = BK_READ;
                    end
                end
            end
            BK_WRITE:
                state_next = BK_DONE;
            BK_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // memory write controls
    always_comb
    begin
        meta_we = 1'b0;
        full_we = 1'b0;
        meta_wd = '0;
        unique case (state_reg)
            BK_CLEAR:
                meta_we = 1'b1;
            BK_WRITE:
            begin
                meta_we = 1'b1;
                if (cmd_op == OP_STORE)
                begin
                    full_we = 1'b1;
                    meta_wd = {cmd_len, 1'b1};
                end
                else
                begin
                    meta_wd = {cmd_len, 1'b0};
                end
            end
            default:
            begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[addr_reg] <= meta_wd;
        if (full_we)
        begin
            key_mem[addr_reg]  <= cmd_key;
            hdl_mem[addr_reg]  <= cmd_handle;
            plen_mem[addr_reg] <= cmd_plen;
        end
        meta_rd_reg <= meta_mem[addr_reg];
        key_rd_reg  <= key_mem[addr_reg];
        hdl_rd_reg  <= hdl_mem[addr_reg];
        plen_rd_reg <= plen_mem[addr_reg];
        eq_reg      <= ((key_rd_reg ^ cmd_key) & key_mask) == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            addr_reg      <= '0;
            probes_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probes_reg    <= probes_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fh_reg <= fh_next;
        fl_reg <= fl_next;
    end

    assign cmd_ready    = state_reg == BK_DONE;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_handle = fh_reg;
    assign found_length = fl_reg;

endmodule

// ===== src/linear_probe_key_index_top.sv =====
// Top level of the linear-probe key index.
// Key bytes are taken one per cycle while in_ready is high and folded into an
// FNV-1a hash; the item with key_last posts a command to a one-entry queue, and
// the front end then holds in_ready low until the back end finishes that command.
// The back end walks buckets from hash mod BUCKETS (BUCKETS must be a power of
// two); each bucket visited passes through BK_READ (memory read), BK_CHECK (key
// compare) and BK_CMP (decide), and a store or remove that hits adds BK_WRITE
// before BK_DONE; the memory reads are registered. A new command starts only once
// the previous result has been taken. After reset a clearing pass empties every
// bucket before the first command runs.
module linear_probe_key_index_top
    import lpki_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int KEY_BYTES = 32,
    parameter int PAYLOAD_LIMIT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        has_byte,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [31:0] value_handle,
    input  logic [15:0] payload_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] found_handle,
    output logic [15:0] found_length
);

    localparam int KW = $clog2(KEY_BYTES);
    localparam int BW = $clog2(BUCKETS);

    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [1:0]             cmd_op;
    logic                   cmd_bad;
    logic [31:0]            cmd_hash;
    logic [KW-1:0]          cmd_len;
    logic [KEY_BYTES*8-1:0] cmd_key;
    logic [31:0]            cmd_handle;
    logic [15:0]            cmd_plen;

    lpki_front #(.KEY_BYTES(KEY_BYTES), .PAYLOAD_LIMIT(PAYLOAD_LIMIT), .KW(KW)) u_front
    (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .has_byte, .key_byte,
        .key_last, .value_handle, .payload_length,
        .cmd_valid, .cmd_ready, .cmd_op, .cmd_bad, .cmd_hash, .cmd_len,
        .cmd_key, .cmd_handle, .cmd_plen
    );

    lpki_back #(.BUCKETS(BUCKETS), .KEY_BYTES(KEY_BYTES), .KW(KW), .BW(BW)) u_back
    (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_op, .cmd_bad, .cmd_hash,
        .cmd_len, .cmd_key, .cmd_handle, .cmd_plen,
        .out_valid, .out_ready, .status, .found_handle, .found_length
    );

endmodule

// ===== src/lpki_checker.sv =====
// Port-level checks for the key index, bound to the top level.
module lpki_checker
    import lpki_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] found_handle,
    input logic [15:0] found_length
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_handle == '0 && found_length == '0)
        else $error("nonzero fields on failed result");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result during reset");

endmodule

bind linear_probe_key_index_top lpki_checker u_checker
(
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .found_handle, .found_length
);
